// ----- rtl/ycc2rgb_pkg.sv -----
// ---------------------------------------------------------------------------
// ycc2rgb_pkg
// Shared widths, offsets and arithmetic helpers for the YCbCr to RGB converter.
// ---------------------------------------------------------------------------
package ycc2rgb_pkg;

   localparam int SAMPLE_W = 16;   // luma and chroma sample width
   localparam int CH_W     = 20;   // working width of the channel sums
   localparam int PIX_W    = 8;    // output channel width

   localparam logic signed [CH_W-1:0] R_OFFSET = CH_W'(819);
   localparam logic signed [CH_W-1:0] B_OFFSET = CH_W'(1024);
   localparam logic [PIX_W-1:0]       CH_MAX   = PIX_W'(255);

   typedef logic signed [CH_W-1:0] chan_type;

   // Arithmetic shift right that rounds toward zero, like a signed C division
   // by a power of two. Called with constant shift amounts only.
   function automatic chan_type trunc_shr(input chan_type x, input int unsigned k);
      chan_type bias;
      bias = x[CH_W-1] ? ((CH_W'(1) << k) - CH_W'(1)) : '0;
      return (x + bias) >>> k;
   endfunction

endpackage

// ----- rtl/ycc2rgb_clamp.sv -----
// ---------------------------------------------------------------------------
// ycc2rgb_clamp
// Saturates one signed channel sum to an 8-bit level: zero or below gives 0,
// otherwise the value divided by four, capped at full scale.
// ---------------------------------------------------------------------------
module ycc2rgb_clamp
   import ycc2rgb_pkg::*;
(
   input  chan_type         value,
   output logic [PIX_W-1:0] level
);

   logic non_pos;
   logic over;

   assign non_pos = value[CH_W-1] | (value == '0);
   // value >> 2 exceeds full scale when any bit above the 8-bit window is set
   assign over    = |value[CH_W-2:PIX_W+2];

   always_comb begin
      if (non_pos) begin
         level = '0;
      end else if (over) begin
         level = CH_MAX;
      end else begin
         level = value[PIX_W+1:2];
      end
   end

endmodule

// ----- rtl/ycbcr_to_rgb_pixel_convert.sv -----
// Throughput: one pixel per cycle while rsp_tready does not stall; four
//   register stages (chroma select, red/blue sums, green sum, saturation
//   into the output register) from an accepted req_ transaction to rsp_tvalid.
// A stall on rsp_tready holds each occupied stage with no empty stage after it; other stages still advance and fill.
// Reset clears all stage valid bits and sets chroma_halved to 0.
// ---------------------------------------------------------------------------
// ycbcr_to_rgb_pixel_convert
// Pipelined conversion of one signed YCbCr pixel to 8-bit blue, green, red,
// with optional averaging of half-width chroma on odd columns other than the last.
// ---------------------------------------------------------------------------
module ycbcr_to_rgb_pixel_convert
   import ycc2rgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: luma[15:0], cb_here[31:16], cr_here[47:32],
   //            cb_right[63:48], cr_right[79:64]
   input  logic [79:0] req_tdata,
   input  logic        req_tuser,   // odd_column
   input  logic        req_tlast,   // last_column
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: blue[7:0], green[15:8], red[23:16]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_data,    // chroma_halved
   input  logic        csr_valid,
   output logic        csr_ready
);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SAMPLE_W:0]   sum17_type;

   // configuration register
   logic chroma_halved_ff, chroma_halved_in;

   // stage enables
   logic en1, en2, en3, en_out;

   // stage 1: selected chroma
   logic       s1_valid_ff, s1_valid_in;
   sample_type s1_y_ff, s1_cb_ff, s1_cr_ff;
   sample_type s1_cb_in, s1_cr_in;

   // stage 2: red and blue sums
   logic       s2_valid_ff, s2_valid_in;
   sample_type s2_y_ff;
   chan_type   s2_r_ff, s2_b_ff, s2_r_in, s2_b_in;

   // stage 3: green sum
   logic       s3_valid_ff, s3_valid_in;
   chan_type   s3_r_ff, s3_b_ff, s3_g_ff, s3_g_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   sample_type in_y, in_cb, in_cr, in_cb_r, in_cr_r;
   sum17_type  cb_sum, cr_sum;
   chan_type   cr_x, cb_x, y2, y3;
   logic [PIX_W-1:0] blue_lvl, green_lvl, red_lvl;

   // ---------------- handshake ----------------
   assign en_out     = !rsp_valid_ff || rsp_tready;
   assign en3        = !s3_valid_ff || en_out;
   assign en2        = !s2_valid_ff || en3;
   assign en1        = !s1_valid_ff || en2;
   assign req_tready = en1;
   assign csr_ready  = 1'b1;

   assign chroma_halved_in = (csr_valid && csr_ready) ? csr_data : chroma_halved_ff;

   assign s1_valid_in  = en1 ? req_tvalid  : s1_valid_ff;
   assign s2_valid_in  = en2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = en3 ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = en_out ? s3_valid_ff : rsp_valid_ff;

   // ---------------- stage 1: chroma select ----------------
   assign in_y    = req_tdata[15:0];
   assign in_cb   = req_tdata[31:16];
   assign in_cr   = req_tdata[47:32];
   assign in_cb_r = req_tdata[63:48];
   assign in_cr_r = req_tdata[79:64];

   assign cb_sum = sum17_type'(in_cb) + sum17_type'(in_cb_r);
   assign cr_sum = sum17_type'(in_cr) + sum17_type'(in_cr_r);

   always_comb begin
      if (chroma_halved_ff && req_tuser && !req_tlast) begin
         // halve toward zero: add one to negative sums before the shift
         s1_cb_in = SAMPLE_W'((cb_sum + sum17_type'(cb_sum[SAMPLE_W])) >>> 1);
         s1_cr_in = SAMPLE_W'((cr_sum + sum17_type'(cr_sum[SAMPLE_W])) >>> 1);
      end else begin
         s1_cb_in = in_cb;
         s1_cr_in = in_cr;
      end
   end

   // ---------------- stage 2: red and blue ----------------
   assign cr_x = chan_type'(s1_cr_ff);
   assign cb_x = chan_type'(s1_cb_ff);
   assign y2   = chan_type'(s1_y_ff);

   assign s2_r_in = y2 + cr_x + trunc_shr(cr_x, 1) + trunc_shr(cr_x, 3) - R_OFFSET;
   assign s2_b_in = y2 + (cb_x <<< 1) - B_OFFSET;

   // ---------------- stage 3: green ----------------
   assign y3 = chan_type'(s2_y_ff);

   assign s3_g_in = (y3 <<< 1) - trunc_shr(y3, 2) - trunc_shr(s2_r_ff, 1)
                    - trunc_shr(s2_b_ff, 2) - trunc_shr(s2_b_ff, 4);

   // ---------------- stage 4: saturate ----------------
   ycc2rgb_clamp u_clamp_blue  (.value(s3_b_ff), .level(blue_lvl));
   ycc2rgb_clamp u_clamp_green (.value(s3_g_ff), .level(green_lvl));
   ycc2rgb_clamp u_clamp_red   (.value(s3_r_ff), .level(red_lvl));

   assign rsp_data_in = en_out ? {red_lvl, green_lvl, blue_lvl} : rsp_data_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign rsp_tvalid  = rsp_valid_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         chroma_halved_ff <= 1'b0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         chroma_halved_ff <= chroma_halved_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         s3_valid_ff      <= s3_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_y_ff  <= in_y;
         s1_cb_ff <= s1_cb_in;
         s1_cr_ff <= s1_cr_in;
      end
      if (en2) begin
         s2_y_ff <= s1_y_ff;
         s2_r_ff <= s2_r_in;
         s2_b_ff <= s2_b_in;
      end
      if (en3) begin
         s3_r_ff <= s2_r_ff;
         s3_b_ff <= s2_b_ff;
         s3_g_ff <= s3_g_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule
